[hdl/bhs_pkg.sv]
package bhs_pkg;
  localparam int MAX_BUCKETS = 64;
  localparam int SLOTS_PER_BUCKET = 3;
  localparam int SPILL_DEPTH = 16;
  localparam int KEY_W = 31;
  localparam int CNT_W = 7;
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int SLOT_DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int SLOT_AW = $clog2(SLOT_DEPTH);
  localparam int SLOT_IW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SPILL_IW = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] ST_BUCKET  = 3'd0;
  localparam logic [2:0] ST_SPILL   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FOUND   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_ERASED  = 3'd5;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bucket;
  } job_t;
endpackage

[hdl/bucketed_hash_set_with_overflow_top.sv]
// Flow: the front computes the bucket by a serial modulo, the job passes a
// two-entry queue, then the back scanner reads and compares each bucket slot
// in turn, scans the overflow entries and posts the result.
// The front takes no new item while its serial modulo runs or its job waits
// to be handed on; the back scan overlaps the next modulo through a two-entry queue.
// Reset (rst, synchronous): all valid marks cleared at once, bucket count 64.
module bucketed_hash_set_with_overflow_top import bhs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       cmd,
  input  logic [KEY_W-1:0] key,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       status,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);
  logic [CNT_W-1:0] bucket_count;
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  always_ff @(posedge clk) begin
    if (rst) bucket_count <= CNT_W'(64);
    else if (cfg_we) bucket_count <= cfg_data;
  end

  bhs_front u_front (.clk, .rst, .push, .full, .cmd, .key, .bucket_count,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job));
  bhs_queue u_queue (.clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job));
  bhs_back u_back (.clk, .rst, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .empty, .pop, .status);

  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= ST_ERASED) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status))) else $error("result lost");
  a_none: assert property (@(posedge clk) disable iff (rst)
    (push && !full && cmd == CMD_NONE) |=> !full) else $error("null cmd stuck");
endmodule

[hdl/bhs_front.sv]
// Takes items, computes the bucket by restoring division one bit per cycle.
module bhs_front import bhs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] bucket_count,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);
  localparam int CW = $clog2(KEY_W + 1);
  logic             busy;
  logic             done;
  logic [CW-1:0]    step;
  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] shreg;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] div;
  logic [CNT_W:0]   trial;

  always_comb begin
    if (bucket_count == '0) div = CNT_W'(1);
    else if (bucket_count > CNT_W'(MAX_BUCKETS)) div = CNT_W'(MAX_BUCKETS);
    else div = bucket_count;
  end

  assign trial = {rem[CNT_W-1:0], shreg[KEY_W-1]};
  assign full = busy | done;
  assign job_valid = done;
  assign job.cmd = cmd_r;
  assign job.key = key_r;
  assign job.bucket = rem[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (push && !full) begin
        cmd_r <= cmd;
        key_r <= key;
        shreg <= key;
        rem   <= '0;
        step  <= '0;
        busy  <= (cmd != CMD_NONE);
      end else if (busy) begin
        rem   <= (trial >= {1'b0, div}) ? trial - {1'b0, div} : trial;
        shreg <= shreg << 1;
        step  <= step + CW'(1);
        if (step == CW'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (done && job_ready) done <= 1'b0;
    end
  end
endmodule

[hdl/bhs_queue.sv]
// Short FIFO between the front and back parts.
module bhs_queue import bhs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t         mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;
  logic wr, rd;

  assign in_ready  = (cnt != (QAW+1)'(QDEPTH));
  assign out_valid = (cnt != '0);
  assign out_job   = mem[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + QAW'(1);
      if (rd) rp <= rp + QAW'(1);
      cnt <= cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end
endmodule

[hdl/bhs_back.sv]
// Scans bucket slots, then overflow entries one per cycle; the slot memory
// has a registered read, so each slot takes an address state and a compare state.
module bhs_back import bhs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SPL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [KEY_W-1:0] slot_key [SLOT_DEPTH];
  logic [SLOT_DEPTH-1:0] slot_valid;
  logic [KEY_W-1:0] spill_key [SPILL_DEPTH];
  logic [SPILL_DEPTH-1:0] spill_valid;

  logic [2:0]       state;
  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [SLOT_AW-1:0] base;
  logic [SLOT_IW-1:0] si;
  logic [SPILL_IW-1:0] pi;
  logic [KEY_W-1:0] rd_key;
  logic [2:0]       res;
  logic [2:0]       res_out;
  logic             res_v;
  logic [SLOT_AW-1:0] addr;

  assign addr = base + SLOT_AW'(si);
  assign job_ready = (state == S_IDLE);
  assign empty = !res_v;
  assign status = res_out;

  always_ff @(posedge clk) begin
    rd_key <= slot_key[addr];
    if (state == S_CMP && cmd_r == CMD_INSERT && !slot_valid[addr])
      slot_key[addr] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (state == S_SPL && cmd_r == CMD_INSERT && !spill_valid[pi])
      spill_key[pi] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      spill_valid <= '0;
      res_v <= 1'b0;
    end else begin
      // output register: a new result moves in as the old one transfers out
      if (state == S_OUT && (!res_v || pop)) begin
        res_v <= 1'b1;
        res_out <= res;
      end else if (res_v && pop) begin
        res_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            cmd_r <= job.cmd;
            key_r <= job.key;
            base  <= SLOT_AW'(job.bucket) * SLOT_AW'(SLOTS_PER_BUCKET);
            si    <= '0;
            pi    <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (cmd_r == CMD_INSERT && !slot_valid[addr]) begin
            slot_valid[addr] <= 1'b1;
            res <= ST_BUCKET;
            state <= S_OUT;
          end else if (cmd_r != CMD_INSERT && slot_valid[addr] && rd_key == key_r) begin
            if (cmd_r == CMD_ERASE) begin
              slot_valid[addr] <= 1'b0;
              res <= ST_ERASED;
            end else res <= ST_FOUND;
            state <= S_OUT;
          end else if (si == SLOT_IW'(SLOTS_PER_BUCKET - 1)) begin
            state <= S_SPL;
          end else begin
            si <= si + SLOT_IW'(1);
            state <= S_RD;
          end
        end
        S_SPL: begin
          if (cmd_r == CMD_INSERT && !spill_valid[pi]) begin
            spill_valid[pi] <= 1'b1;
            res <= ST_SPILL;
            state <= S_OUT;
          end else if (cmd_r != CMD_INSERT && spill_valid[pi] && spill_key[pi] == key_r) begin
            if (cmd_r == CMD_ERASE) begin
              spill_valid[pi] <= 1'b0;
              res <= ST_ERASED;
            end else res <= ST_FOUND;
            state <= S_OUT;
          end else if (pi == SPILL_IW'(SPILL_DEPTH - 1)) begin
            res <= (cmd_r == CMD_INSERT) ? ST_FULL : ST_MISSING;
            state <= S_OUT;
          end else begin
            pi <= pi + SPILL_IW'(1);
          end
        end
        S_OUT: begin
          if (!res_v || pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/hash_set_monitor.sv]
module hash_set_monitor import bhs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  logic [1:0]       cmd,
  input  logic [KEY_W-1:0] key,
  input  logic             empty,
  input  logic             pop,
  input  logic [2:0]       status,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  logic [KEY_W-1:0] slot_key [SLOT_DEPTH];
  logic             slot_valid [SLOT_DEPTH];
  logic [KEY_W-1:0] spill_key [SPILL_DEPTH];
  logic             spill_valid [SPILL_DEPTH];
  logic [CNT_W-1:0] bucket_count;
  logic [2:0]       status_q [$];

  function automatic int buckets_in_use();
    if (bucket_count == 0) return 1;
    if (bucket_count > MAX_BUCKETS) return MAX_BUCKETS;
    return bucket_count;
  endfunction

  // Updates the table state and returns the status the block should report.
  function automatic logic [2:0] apply_op(logic [1:0] op, logic [KEY_W-1:0] k);
    int base;
    base = (k % buckets_in_use()) * SLOTS_PER_BUCKET;
    if (op == CMD_INSERT) begin
      for (int j = 0; j < SLOTS_PER_BUCKET; j++)
        if (!slot_valid[base + j]) begin
          slot_key[base + j] = k;
          slot_valid[base + j] = 1'b1;
          return ST_BUCKET;
        end
      for (int j = 0; j < SPILL_DEPTH; j++)
        if (!spill_valid[j]) begin
          spill_key[j] = k;
          spill_valid[j] = 1'b1;
          return ST_SPILL;
        end
      return ST_FULL;
    end
    for (int j = 0; j < SLOTS_PER_BUCKET; j++)
      if (slot_valid[base + j] && slot_key[base + j] == k) begin
        if (op == CMD_ERASE) begin
          slot_valid[base + j] = 1'b0;
          return ST_ERASED;
        end
        return ST_FOUND;
      end
    for (int j = 0; j < SPILL_DEPTH; j++)
      if (spill_valid[j] && spill_key[j] == k) begin
        if (op == CMD_ERASE) begin
          spill_valid[j] = 1'b0;
          return ST_ERASED;
        end
        return ST_FOUND;
      end
    return ST_MISSING;
  endfunction

  always @(posedge clk) begin
    logic [2:0] want;
    if (rst) begin
      for (int i = 0; i < SLOT_DEPTH; i++) slot_valid[i] = 1'b0;
      for (int i = 0; i < SPILL_DEPTH; i++) spill_valid[i] = 1'b0;
      bucket_count = 7'd64;
      status_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) bucket_count = cfg_data;
      if (pop && !empty) begin
        if (status_q.size() == 0) begin
          $display("%0t: result transfer with none expected: status %0d", $time, status);
          fail_count <= fail_count + 1;
        end else begin
          want = status_q.pop_front();
          if (status !== want) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, want, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      // command three is dropped by the block without a result
      if (push && !full && cmd != CMD_NONE) status_q = {status_q, apply_op(cmd, key)};
    end
    pending <= status_q.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import bhs_pkg::*;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic             empty;
  logic             pop;
  logic [2:0]       status;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct;
  int pop_stall_pct;
  int cur_buckets;
  logic hold_req;
  logic hold_seen;
  int hold_left;
  int quiet_cycles;

  bucketed_hash_set_with_overflow_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .key(key),
    .empty(empty), .pop(pop), .status(status), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  hash_set_monitor i_monitor (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .key(key),
    .empty(empty), .pop(pop), .status(status), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // receiver; one long hold-off on request so the block backs up into full
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 400;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [KEY_W-1:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= op;
    key <= k;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_buckets(logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_buckets = (v == 0) ? 1 : (v > MAX_BUCKETS) ? MAX_BUCKETS : v;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return KEY_W'($urandom_range(0, 9) * cur_buckets + $urandom_range(0, 2));
    if (sel == 7) return KEY_W'({KEY_W{1'b1}} - $urandom_range(0, 3));
    return KEY_W'($urandom);
  endfunction

  function automatic logic [1:0] pick_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return CMD_INSERT;
    if (sel < 70) return CMD_FIND;
    if (sel < 96) return CMD_ERASE;
    return CMD_NONE;
  endfunction

  initial begin
    logic [CNT_W-1:0] settings [7];
    int idle_modes [4];
    int stall_modes [4];
    settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd13, 7'd64};
    idle_modes = '{0, 77, 0, 28};
    stall_modes = '{0, 0, 77, 28};
    rst = 1'b1;
    push = 1'b0;
    cmd = CMD_INSERT;
    key = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    cur_buckets = MAX_BUCKETS;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one bucket: fill its slots and the whole overflow store, then one more
    write_buckets(7'd1);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, {KEY_W{1'b1}});
    for (int i = 0; i < 18; i++) send_item(CMD_INSERT, 31'd100 + i);
    send_item(CMD_FIND, {KEY_W{1'b1}});
    send_item(CMD_ERASE, '0);
    send_item(CMD_FIND, '0);
    send_item(CMD_ERASE, 31'd12345);
    send_item(CMD_NONE, 31'd117);
    send_item(CMD_ERASE, 31'd117);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_buckets(settings[ph]);
      send_idle_pct = idle_modes[ph % 4];
      pop_stall_pct = stall_modes[ph % 4];
      if (ph == 2) hold_req <= 1'b1;
      for (int n = 0; n < 68; n++) send_item(pick_op(), pick_key());
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
